[hw/rtl/mbf_pkg.sv]
// shared types and constants for the metaball field pixel shader
`timescale 1ns / 1ps

package mbf_pkg;

    // fixed field widths
    localparam int COORD_BITS = 10;
    localparam int SLOT_W     = 4;
    localparam int JIT_W      = 7;
    localparam int ACT_W      = 5;
    localparam int RECIP_W    = 41;
    localparam int THR_W      = 28;
    localparam int COLOR_W    = 8;
    localparam int COV_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_COLORS = 3;

    // fixed point of the falloff
    localparam int Q_FRAC      = 24;
    localparam int T_W         = Q_FRAC + 1;
    localparam int S_LSB       = 32;
    localparam int S_LIMIT_BIT = 56;
    localparam logic [T_W-1:0] ONE_Q24 = T_W'(1 << Q_FRAC);

    // split of the reciprocal for the partial products
    localparam int RL_W = 21;
    localparam int RH_W = RECIP_W - RL_W;

    // register stages from a cell's position input to its falloff value
    localparam int CELL_DEPTH = 8;

    // register reset values
    localparam logic [ACT_W-1:0]   RST_ACTIVE = ACT_W'(13);
    localparam logic [RECIP_W-1:0] RST_RECIP  = RECIP_W'(180143985);
    localparam logic [THR_W-1:0]   RST_THR    = THR_W'(2516582);
    localparam logic [COLOR_W-1:0] RST_RED    = COLOR_W'(0);
    localparam logic [COLOR_W-1:0] RST_GREEN  = COLOR_W'(255);
    localparam logic [COLOR_W-1:0] RST_BLUE   = COLOR_W'(60);

    // color slots
    localparam int COL_RED   = 0;
    localparam int COL_GREEN = 1;
    localparam int COL_BLUE  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE = 3'd0,
        CFG_RECIP  = 3'd1,
        CFG_THR    = 3'd2,
        CFG_RED    = 3'd3,
        CFG_GREEN  = 3'd4,
        CFG_BLUE   = 3'd5
    } t_cfg_idx;

    typedef enum logic [0:0] {
        OP_LOAD  = 1'b0,
        OP_SHADE = 1'b1
    } t_op;

    typedef struct packed {
        t_op                   operation;
        logic [SLOT_W-1:0]     center_slot;
        logic [COORD_BITS-1:0] center_x;
        logic [COORD_BITS-1:0] center_y;
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [JIT_W-1:0]      jitter_x;
        logic [JIT_W-1:0]      jitter_y;
    } t_in_item;

    typedef struct packed {
        logic [COV_W-1:0]   coverage;
        logic [COLOR_W-1:0] out_red;
        logic [COLOR_W-1:0] out_green;
        logic [COLOR_W-1:0] out_blue;
    } t_out_item;

    // marks of a subsample on the sum path
    typedef struct packed {
        logic valid;
        logic last;
    } t_smp_ctl;

endpackage

[hw/rtl/metaball_field_pixel_shader.sv]
// top level: configuration, subsample issue, coverage count and result register
`timescale 1ns / 1ps

// Metaball field pixel shader.
// Input channel (i_in_valid / o_in_stall, payload i_in_data) carries two kinds of
// transaction. A load writes one center slot. A shade starts GRID_SIDE x GRID_SIDE
// jittered subsamples of one pixel; one subsample enters the cell row per cycle
// while the row is not frozen, and the next shade is taken in the cycle of the
// last issue. A load waits until every accepted shade has reached the result
// register, because it rewrites a cell in the row.
// Each subsample walks the row of MAX_CENTERS cells, one cell per cycle unless
// frozen, each active cell adding its center's falloff; the sum leaves the last
// cell and is compared with the threshold. A shade's result appears on o_out_valid /
// o_out_data once its last subsample has been counted; a load gives none.
// The configuration port (i_cfg_valid / o_cfg_ready, index and data) is always ready
// and must be written only while the block is idle, which the block does not enforce.
// Reset sets the configuration registers to their defaults and empties the row;
// center slots hold no defined value until loaded.
// When the receiver stalls, the result register holds; once a further finished
// pixel needs the register, the whole row and the issue freeze until it drains.

module metaball_field_pixel_shader #(
    parameter int MAX_CENTERS = 16,
    parameter int GRID_SIDE   = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  mbf_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output mbf_pkg::t_out_item                 o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mbf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mbf_pkg::RECIP_W-1:0]        i_cfg_data
);

    localparam int SPAN    = 100 * GRID_SIDE;
    localparam int CELLS   = GRID_SIDE * GRID_SIDE;
    localparam int POS_W   = $clog2(((1 << mbf_pkg::COORD_BITS) - 1) * SPAN
                                    + 100 * (GRID_SIDE - 1) + 128);
    localparam int ACC_W   = mbf_pkg::Q_FRAC + $clog2(MAX_CENTERS + 1);
    localparam int THR_W   = mbf_pkg::THR_W;
    localparam int CMP_W   = (ACC_W > THR_W) ? ACC_W : THR_W;
    localparam int GI_W    = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
    localparam int OFF_W   = (GRID_SIDE > 1) ? $clog2(100 * (GRID_SIDE - 1) + 1) : 1;
    localparam int CNT_W   = $clog2(CELLS + 1);
    localparam int REM_W   = $clog2(2 * CELLS);
    localparam int COLOR_W = mbf_pkg::COLOR_W;
    localparam int NCOL    = mbf_pkg::NUM_COLORS;
    localparam int DIVB    = $clog2(CELLS) + 1;
    localparam int SQ      = COLOR_W + DIVB;
    localparam int KQ      = ((1 << SQ) + CELLS - 1) / CELLS;
    localparam int QP_W    = COLOR_W + SQ + 1;
    localparam int RC_W    = COLOR_W + DIVB + 1;
    localparam int PEND_W  = $clog2(2 * MAX_CENTERS + 2 * mbf_pkg::CELL_DEPTH + 4);

    localparam logic [GI_W-1:0]  G_LAST   = GI_W'(GRID_SIDE - 1);
    localparam logic [OFF_W-1:0] OFF_STEP = OFF_W'(100);
    localparam logic [REM_W-1:0] CELLS_R  = REM_W'(CELLS);

    // configuration registers
    logic [mbf_pkg::ACT_W-1:0]   r_active;
    logic [mbf_pkg::RECIP_W-1:0] r_recip;
    logic [THR_W-1:0]            r_thr;
    logic [COLOR_W-1:0]          r_color [0:NCOL-1];

    // color split into quotient and remainder by the subsample count
    logic [COLOR_W-1:0] r_qc [0:NCOL-1];
    logic [REM_W-1:0]   r_rc [0:NCOL-1];

    // subsample issue
    logic              r_busy;
    logic [GI_W-1:0]   r_p;
    logic [GI_W-1:0]   r_q;
    logic [OFF_W-1:0]  r_xoff;
    logic [OFF_W-1:0]  r_yoff;
    logic [POS_W-1:0]  r_xbase;
    logic [POS_W-1:0]  r_ybase;
    logic [PEND_W-1:0] r_pend;

    // coverage collection and result register
    logic [CNT_W-1:0]   r_cnt;
    logic [COLOR_W-1:0] r_quo [0:NCOL-1];
    logic [REM_W-1:0]   r_rem [0:NCOL-1];
    logic               r_out_valid;
    mbf_pkg::t_out_item r_out;

    logic               w_adv;
    logic               w_iss_last;
    logic               w_iss_free;
    logic               w_can_take;
    logic               w_in_take;
    logic               w_take_shade;
    logic               w_take_load;
    logic [POS_W-1:0]   w_sx;
    logic [POS_W-1:0]   w_sy;
    mbf_pkg::t_smp_ctl  w_iss_ctl;
    mbf_pkg::t_smp_ctl  w_exit_ctl;
    logic [ACC_W-1:0]   w_exit_acc;
    logic               w_cov;
    logic               w_step;
    logic               w_push;
    logic [CNT_W-1:0]   n_cnt;
    logic [REM_W-1:0]   w_rsum [0:NCOL-1];
    logic               w_wrap [0:NCOL-1];
    logic [REM_W-1:0]   n_rem  [0:NCOL-1];
    logic [COLOR_W-1:0] n_quo  [0:NCOL-1];
    logic [QP_W-1:0]    w_qprod [0:NCOL-1];
    logic [COLOR_W-1:0] w_qc   [0:NCOL-1];
    logic [RC_W-1:0]    w_rc   [0:NCOL-1];

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= mbf_pkg::RST_ACTIVE;
            r_recip  <= mbf_pkg::RST_RECIP;
            r_thr    <= mbf_pkg::RST_THR;
            r_color[mbf_pkg::COL_RED]   <= mbf_pkg::RST_RED;
            r_color[mbf_pkg::COL_GREEN] <= mbf_pkg::RST_GREEN;
            r_color[mbf_pkg::COL_BLUE]  <= mbf_pkg::RST_BLUE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mbf_pkg::CFG_ACTIVE: r_active <= i_cfg_data[mbf_pkg::ACT_W-1:0];
                mbf_pkg::CFG_RECIP:  r_recip  <= i_cfg_data;
                mbf_pkg::CFG_THR:    r_thr    <= i_cfg_data[THR_W-1:0];
                mbf_pkg::CFG_RED:    r_color[mbf_pkg::COL_RED]   <= i_cfg_data[COLOR_W-1:0];
                mbf_pkg::CFG_GREEN:  r_color[mbf_pkg::COL_GREEN] <= i_cfg_data[COLOR_W-1:0];
                mbf_pkg::CFG_BLUE:   r_color[mbf_pkg::COL_BLUE]  <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // quotient by reciprocal multiply, remainder by back-multiply
    always_comb begin
        for (int c = 0; c < NCOL; c++) begin
            w_qprod[c] = QP_W'(r_color[c]) * QP_W'(KQ);
            w_qc[c]    = COLOR_W'(w_qprod[c] >> SQ);
            w_rc[c]    = RC_W'(r_color[c]) - RC_W'(w_qc[c]) * RC_W'(CELLS);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NCOL; c++) begin
            r_qc[c] <= w_qc[c];
            r_rc[c] <= REM_W'(w_rc[c]);
        end
    end

    // input acceptance
    assign w_iss_last   = r_busy && (r_p == G_LAST) && (r_q == G_LAST);
    assign w_iss_free   = !r_busy || (w_adv && w_iss_last);
    assign w_can_take   = (i_in_data.operation == mbf_pkg::OP_SHADE)
                        ? w_iss_free : (!r_busy && (r_pend == '0));
    assign o_in_stall   = !w_can_take;
    assign w_in_take    = i_in_valid && w_can_take;
    assign w_take_shade = w_in_take && (i_in_data.operation == mbf_pkg::OP_SHADE);
    assign w_take_load  = w_in_take && (i_in_data.operation == mbf_pkg::OP_LOAD);

    // subsample issue: q walks the rows inside each column p
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_p    <= '0;
            r_q    <= '0;
            r_xoff <= '0;
            r_yoff <= '0;
        end else if (w_take_shade) begin
            r_busy <= 1'b1;
            r_p    <= '0;
            r_q    <= '0;
            r_xoff <= '0;
            r_yoff <= '0;
        end else if (r_busy && w_adv) begin
            if (w_iss_last) begin
                r_busy <= 1'b0;
            end else if (r_q == G_LAST) begin
                r_q    <= '0;
                r_yoff <= '0;
                r_p    <= r_p + GI_W'(1);
                r_xoff <= r_xoff + OFF_STEP;
            end else begin
                r_q    <= r_q + GI_W'(1);
                r_yoff <= r_yoff + OFF_STEP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_shade) begin
            r_xbase <= POS_W'(i_in_data.pixel_x) * POS_W'(SPAN) + POS_W'(i_in_data.jitter_x);
            r_ybase <= POS_W'(i_in_data.pixel_y) * POS_W'(SPAN) + POS_W'(i_in_data.jitter_y);
        end
    end

    assign w_sx           = r_xbase + POS_W'(r_xoff);
    assign w_sy           = r_ybase + POS_W'(r_yoff);
    assign w_iss_ctl.valid = r_busy;
    assign w_iss_ctl.last  = w_iss_last;

    // row of center cells
    mbf_chain #(
        .MAX_CENTERS (MAX_CENTERS),
        .POS_W       (POS_W),
        .ACC_W       (ACC_W)
    ) u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_ld_en   (w_take_load),
        .i_ld_slot (i_in_data.center_slot),
        .i_ld_cx   (POS_W'(i_in_data.center_x) * POS_W'(SPAN)),
        .i_ld_cy   (POS_W'(i_in_data.center_y) * POS_W'(SPAN)),
        .i_active  (r_active),
        .i_recip   (r_recip),
        .i_sx      (w_sx),
        .i_sy      (w_sy),
        .i_ctl     (w_iss_ctl),
        .o_ctl     (w_exit_ctl),
        .o_acc     (w_exit_acc)
    );

    // freeze everything when a finished pixel finds the result register blocked
    assign w_adv  = !(w_exit_ctl.valid && w_exit_ctl.last && r_out_valid && i_out_stall);
    assign w_step = w_adv && w_exit_ctl.valid;
    assign w_push = w_step && w_exit_ctl.last;

    // coverage test and running color sums
    assign w_cov = CMP_W'(w_exit_acc) > CMP_W'(r_thr);
    assign n_cnt = r_cnt + CNT_W'(w_cov);

    always_comb begin
        for (int c = 0; c < NCOL; c++) begin
            w_rsum[c] = r_rem[c] + (w_cov ? r_rc[c] : '0);
            w_wrap[c] = (w_rsum[c] >= CELLS_R);
            n_rem[c]  = w_wrap[c] ? (w_rsum[c] - CELLS_R) : w_rsum[c];
            n_quo[c]  = r_quo[c] + (w_cov ? r_qc[c] : '0) + COLOR_W'(w_wrap[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            for (int c = 0; c < NCOL; c++) begin
                r_quo[c] <= '0;
                r_rem[c] <= '0;
            end
        end else if (w_step) begin
            r_cnt <= w_exit_ctl.last ? '0 : n_cnt;
            for (int c = 0; c < NCOL; c++) begin
                r_quo[c] <= w_exit_ctl.last ? '0 : n_quo[c];
                r_rem[c] <= w_exit_ctl.last ? '0 : n_rem[c];
            end
        end
    end

    // pixels accepted and not yet in the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + PEND_W'(w_take_shade) - PEND_W'(w_push);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out.coverage  <= mbf_pkg::COV_W'(n_cnt);
            r_out.out_red   <= n_quo[mbf_pkg::COL_RED];
            r_out.out_green <= n_quo[mbf_pkg::COL_GREEN];
            r_out.out_blue  <= n_quo[mbf_pkg::COL_BLUE];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a subsample leaving the row always belongs to a pixel still counted as pending
    a_exit_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit_ctl.valid |-> (r_pend != '0))
        else $error("subsample left the row with no pending pixel");

    // issuing implies a pending pixel
    a_busy_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pend != '0))
        else $error("issue active with no pending pixel");

    // a finished pixel never overwrites a held result
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !(r_out_valid && i_out_stall))
        else $error("result register overwritten while stalled");

    // an accepted shade starts issue from the first subsample
    a_shade_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take_shade |=> (r_busy && (r_p == '0) && (r_q == '0)))
        else $error("shade transaction did not start issue");

endmodule

[hw/rtl/mbf_cell.sv]
// one center cell: falloff of its center at the passing subsample, added to the running sum
`timescale 1ns / 1ps

module mbf_cell #(
    parameter int IDX   = 0,
    parameter int POS_W = 19,
    parameter int ACC_W = 29
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic                              i_ld_en,
    input  logic [mbf_pkg::SLOT_W-1:0]        i_ld_slot,
    input  logic [POS_W-1:0]                  i_ld_cx,
    input  logic [POS_W-1:0]                  i_ld_cy,
    input  logic [mbf_pkg::ACT_W-1:0]         i_active,
    input  logic [mbf_pkg::RECIP_W-1:0]       i_recip,
    input  logic [POS_W-1:0]                  i_sx,
    input  logic [POS_W-1:0]                  i_sy,
    output logic [POS_W-1:0]                  o_sx,
    output logic [POS_W-1:0]                  o_sy,
    input  mbf_pkg::t_smp_ctl                 i_acc_ctl,
    input  logic [ACC_W-1:0]                  i_acc,
    output mbf_pkg::t_smp_ctl                 o_acc_ctl,
    output logic [ACC_W-1:0]                  o_acc
);

    localparam int SQ_W   = 2 * POS_W;
    localparam int D2_W   = SQ_W + 1;
    localparam int DL_W   = (D2_W + 1) / 2;
    localparam int DH_W   = D2_W - DL_W;
    localparam int RL_W   = mbf_pkg::RL_W;
    localparam int RH_W   = mbf_pkg::RH_W;
    localparam int MIDA_W = DL_W + mbf_pkg::RECIP_W + 1;
    localparam int MIDB_W = DH_W + mbf_pkg::RECIP_W + 1;
    localparam int PROD_W = D2_W + mbf_pkg::RECIP_W;
    localparam int T_W    = mbf_pkg::T_W;
    localparam int TT_W   = 2 * T_W;
    localparam int QF     = mbf_pkg::Q_FRAC;

    logic [POS_W-1:0]  r_cx;
    logic [POS_W-1:0]  r_cy;
    logic [POS_W-1:0]  r_sx;
    logic [POS_W-1:0]  r_sy;
    logic [POS_W-1:0]  r_dx;
    logic [POS_W-1:0]  r_dy;
    logic [SQ_W-1:0]   r_dx2;
    logic [SQ_W-1:0]   r_dy2;
    logic [D2_W-1:0]   r_d2;
    logic [DL_W+RL_W-1:0] r_ll;
    logic [DL_W+RH_W-1:0] r_lh;
    logic [DH_W+RL_W-1:0] r_hl;
    logic [DH_W+RH_W-1:0] r_hh;
    logic [MIDA_W-1:0] r_mida;
    logic [MIDB_W-1:0] r_midb;
    logic [T_W-1:0]    r_t;
    logic [TT_W-1:0]   r_tt;
    logic [T_W-1:0]    r_t7;
    logic [TT_W-1:0]   r_fp;
    logic [ACC_W-1:0]  r_acc;
    mbf_pkg::t_smp_ctl r_actl;

    logic [POS_W-1:0]  w_dx;
    logic [POS_W-1:0]  w_dy;
    logic [DL_W-1:0]   w_dl;
    logic [DH_W-1:0]   w_dh;
    logic [RL_W-1:0]   w_rl;
    logic [RH_W-1:0]   w_rh;
    logic [PROD_W-1:0] w_prod;
    logic              w_over;
    logic [T_W-1:0]    w_t;
    logic [T_W-1:0]    w_f;
    logic              w_on;
    logic              w_ld;

    // center store, written by a load to this slot
    assign w_ld = i_ld_en && (32'(i_ld_slot) == 32'(IDX));

    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            r_cx <= i_ld_cx;
            r_cy <= i_ld_cy;
        end
    end

    // distance terms
    assign w_dx = (i_sx >= r_cx) ? (i_sx - r_cx) : (r_cx - i_sx);
    assign w_dy = (i_sy >= r_cy) ? (i_sy - r_cy) : (r_cy - i_sy);

    // operand halves of d2 times reciprocal
    assign w_dl = r_d2[DL_W-1:0];
    assign w_dh = r_d2[D2_W-1:DL_W];
    assign w_rl = i_recip[RL_W-1:0];
    assign w_rh = i_recip[mbf_pkg::RECIP_W-1:RL_W];

    // full product, range check and 1 - s
    assign w_prod = PROD_W'(r_mida) + (PROD_W'(r_midb) << DL_W);
    assign w_over = |w_prod[PROD_W-1:mbf_pkg::S_LIMIT_BIT];
    assign w_t    = w_over ? '0
                  : (mbf_pkg::ONE_Q24
                     - T_W'(w_prod[mbf_pkg::S_LIMIT_BIT-1:mbf_pkg::S_LSB]));

    // cubed falloff, gated when the cell is past the active count
    assign w_f  = r_fp[QF+T_W-1:QF];
    assign w_on = (32'(i_active) > 32'(IDX));

    // falloff pipeline, frozen with the rest of the chain
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sx   <= i_sx;
            r_sy   <= i_sy;
            r_dx   <= w_dx;
            r_dy   <= w_dy;
            r_dx2  <= SQ_W'(r_dx) * SQ_W'(r_dx);
            r_dy2  <= SQ_W'(r_dy) * SQ_W'(r_dy);
            r_d2   <= D2_W'(r_dx2) + D2_W'(r_dy2);
            r_ll   <= (DL_W + RL_W)'(w_dl) * (DL_W + RL_W)'(w_rl);
            r_lh   <= (DL_W + RH_W)'(w_dl) * (DL_W + RH_W)'(w_rh);
            r_hl   <= (DH_W + RL_W)'(w_dh) * (DH_W + RL_W)'(w_rl);
            r_hh   <= (DH_W + RH_W)'(w_dh) * (DH_W + RH_W)'(w_rh);
            r_mida <= MIDA_W'(r_ll) + (MIDA_W'(r_lh) << RL_W);
            r_midb <= MIDB_W'(r_hl) + (MIDB_W'(r_hh) << RL_W);
            r_t    <= w_t;
            r_tt   <= TT_W'(r_t) * TT_W'(r_t);
            r_t7   <= r_t;
            r_fp   <= TT_W'(r_tt[QF+T_W-1:QF]) * TT_W'(r_t7);
            r_acc  <= i_acc + (w_on ? ACC_W'(w_f) : '0);
        end
    end

    // sum path marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_actl <= '0;
        end else if (i_adv) begin
            r_actl <= i_acc_ctl;
        end
    end

    assign o_sx      = r_sx;
    assign o_sy      = r_sy;
    assign o_acc     = r_acc;
    assign o_acc_ctl = r_actl;

endmodule

[hw/rtl/mbf_chain.sv]
// row of center cells with the delay line that aligns the sum path to the first cell
`timescale 1ns / 1ps

module mbf_chain #(
    parameter int MAX_CENTERS = 16,
    parameter int POS_W       = 19,
    parameter int ACC_W       = 29
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_ld_en,
    input  logic [mbf_pkg::SLOT_W-1:0]    i_ld_slot,
    input  logic [POS_W-1:0]              i_ld_cx,
    input  logic [POS_W-1:0]              i_ld_cy,
    input  logic [mbf_pkg::ACT_W-1:0]     i_active,
    input  logic [mbf_pkg::RECIP_W-1:0]   i_recip,
    input  logic [POS_W-1:0]              i_sx,
    input  logic [POS_W-1:0]              i_sy,
    input  mbf_pkg::t_smp_ctl             i_ctl,
    output mbf_pkg::t_smp_ctl             o_ctl,
    output logic [ACC_W-1:0]              o_acc
);

    localparam int DEPTH = mbf_pkg::CELL_DEPTH;

    mbf_pkg::t_smp_ctl r_dly [0:DEPTH-1];

    logic [POS_W-1:0]  w_sx   [0:MAX_CENTERS];
    logic [POS_W-1:0]  w_sy   [0:MAX_CENTERS];
    logic [ACC_W-1:0]  w_acc  [0:MAX_CENTERS];
    mbf_pkg::t_smp_ctl w_actl [0:MAX_CENTERS];

    // marks wait until the first cell has its falloff ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_dly[k] <= '0;
            end
        end else if (i_adv) begin
            r_dly[0] <= i_ctl;
            for (int k = 1; k < DEPTH; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    assign w_sx[0]   = i_sx;
    assign w_sy[0]   = i_sy;
    assign w_acc[0]  = '0;
    assign w_actl[0] = r_dly[DEPTH-1];

    // one cell per center slot
    for (genvar g = 0; g < MAX_CENTERS; g++) begin : g_cell
        mbf_cell #(
            .IDX   (g),
            .POS_W (POS_W),
            .ACC_W (ACC_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (i_adv),
            .i_ld_en   (i_ld_en),
            .i_ld_slot (i_ld_slot),
            .i_ld_cx   (i_ld_cx),
            .i_ld_cy   (i_ld_cy),
            .i_active  (i_active),
            .i_recip   (i_recip),
            .i_sx      (w_sx[g]),
            .i_sy      (w_sy[g]),
            .o_sx      (w_sx[g+1]),
            .o_sy      (w_sy[g+1]),
            .i_acc_ctl (w_actl[g]),
            .i_acc     (w_acc[g]),
            .o_acc_ctl (w_actl[g+1]),
            .o_acc     (w_acc[g+1])
        );
    end

    assign o_ctl = w_actl[MAX_CENTERS];
    assign o_acc = w_acc[MAX_CENTERS];

endmodule

[tb/metaball_field_pixel_shader_tb.sv]
// testbench for the metaball field pixel shader: predicted coverage and color per shade
`timescale 1ns / 1ps

module metaball_field_pixel_shader_tb;

    localparam int MAX_CTR       = 16;
    localparam int GRID          = 4;
    localparam int SUB_SCALE     = 100 * GRID;
    localparam int CELLS         = GRID * GRID;
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_ITEMS   = 160;
    localparam int RAND_PHASES   = 6;
    localparam int MAX_REPORTS   = 10;
    localparam int RW            = mbf_pkg::RECIP_W;
    localparam int CW            = mbf_pkg::COORD_BITS;

    // predictor of shade results and queue of expected pixels
    class shade_scoreboard;
        logic [mbf_pkg::ACT_W-1:0]   active;
        logic [RW-1:0]               recip;
        logic [mbf_pkg::THR_W-1:0]   thresh;
        logic [mbf_pkg::COLOR_W-1:0] color [mbf_pkg::NUM_COLORS];
        logic [CW-1:0]               ctr_x [MAX_CTR];
        logic [CW-1:0]               ctr_y [MAX_CTR];
        mbf_pkg::t_out_item          expected_q [$];
        int                          mismatches;

        function new();
            int i;
            active                    = mbf_pkg::RST_ACTIVE;
            recip                     = mbf_pkg::RST_RECIP;
            thresh                    = mbf_pkg::RST_THR;
            color[mbf_pkg::COL_RED]   = mbf_pkg::RST_RED;
            color[mbf_pkg::COL_GREEN] = mbf_pkg::RST_GREEN;
            color[mbf_pkg::COL_BLUE]  = mbf_pkg::RST_BLUE;
            mismatches                = 0;
            for (i = 0; i < MAX_CTR; i++) begin
                ctr_x[i] = '0;
                ctr_y[i] = '0;
            end
        endfunction

        function void set_reg(mbf_pkg::t_cfg_idx idx, logic [RW-1:0] val);
            case (idx)
                mbf_pkg::CFG_ACTIVE: active = val[mbf_pkg::ACT_W-1:0];
                mbf_pkg::CFG_RECIP:  recip  = val;
                mbf_pkg::CFG_THR:    thresh = val[mbf_pkg::THR_W-1:0];
                mbf_pkg::CFG_RED:    color[mbf_pkg::COL_RED]   = val[mbf_pkg::COLOR_W-1:0];
                mbf_pkg::CFG_GREEN:  color[mbf_pkg::COL_GREEN] = val[mbf_pkg::COLOR_W-1:0];
                mbf_pkg::CFG_BLUE:   color[mbf_pkg::COL_BLUE]  = val[mbf_pkg::COLOR_W-1:0];
                default: ;
            endcase
        endfunction

        // cubic falloff of one center in q1.24, zero once s reaches one
        function logic [63:0] falloff(logic [63:0] d2);
            logic [127:0] prod;
            logic [63:0]  s, t, t2;
            prod = {64'd0, d2} * {87'd0, recip};
            if (prod >= (128'd1 << mbf_pkg::S_LIMIT_BIT))
                return 64'd0;
            s  = prod[63:0] >> mbf_pkg::S_LSB;
            t  = (64'd1 << mbf_pkg::Q_FRAC) - s;
            t2 = (t * t) >> mbf_pkg::Q_FRAC;
            return (t2 * t) >> mbf_pkg::Q_FRAC;
        endfunction

        // field sum over the active centers against the threshold
        function bit sample_covered(logic [63:0] sx, logic [63:0] sy);
            logic [63:0] cx, cy, dx, dy, sum;
            int          n, i;
            n   = (active > MAX_CTR) ? MAX_CTR : int'(active);
            sum = 64'd0;
            for (i = 0; i < n; i++) begin
                cx  = 64'(ctr_x[i]) * 64'(SUB_SCALE);
                cy  = 64'(ctr_y[i]) * 64'(SUB_SCALE);
                dx  = (sx >= cx) ? sx - cx : cx - sx;
                dy  = (sy >= cy) ? sy - cy : cy - sy;
                sum += falloff(dx * dx + dy * dy);
            end
            return sum > 64'(thresh);
        endfunction

        // accepted input transaction: update the table or predict one pixel
        function void note_input(mbf_pkg::t_in_item it);
            logic [63:0]        count, sx, sy;
            mbf_pkg::t_out_item want;
            int                 p, q;
            if (it.operation == mbf_pkg::OP_LOAD) begin
                ctr_x[it.center_slot] = it.center_x;
                ctr_y[it.center_slot] = it.center_y;
                return;
            end
            count = 64'd0;
            for (p = 0; p < GRID; p++) begin
                for (q = 0; q < GRID; q++) begin
                    sx = 64'(it.pixel_x) * 64'(SUB_SCALE) + 64'(100 * p) + 64'(it.jitter_x);
                    sy = 64'(it.pixel_y) * 64'(SUB_SCALE) + 64'(100 * q) + 64'(it.jitter_y);
                    if (sample_covered(sx, sy))
                        count++;
                end
            end
            want.coverage  = count[mbf_pkg::COV_W-1:0];
            want.out_red   = mbf_pkg::COLOR_W'((64'(color[mbf_pkg::COL_RED]) * count) / CELLS);
            want.out_green = mbf_pkg::COLOR_W'((64'(color[mbf_pkg::COL_GREEN]) * count) / CELLS);
            want.out_blue  = mbf_pkg::COLOR_W'((64'(color[mbf_pkg::COL_BLUE]) * count) / CELLS);
            expected_q = {expected_q, want};
        endfunction

        // accepted output transaction against the oldest prediction
        function void check_result(mbf_pkg::t_out_item got);
            mbf_pkg::t_out_item want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected pixel: coverage %0d rgb %0d %0d %0d",
                             got.coverage, got.out_red, got.out_green, got.out_blue);
                return;
            end
            want = expected_q.pop_front();
            if (got.coverage !== want.coverage || got.out_red !== want.out_red ||
                got.out_green !== want.out_green || got.out_blue !== want.out_blue) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"pixel mismatch: expected cov %0d rgb %0d %0d %0d,",
                              " got cov %0d rgb %0d %0d %0d"},
                             want.coverage, want.out_red, want.out_green, want.out_blue,
                             got.coverage, got.out_red, got.out_green, got.out_blue);
            end
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n     = 1'b0;
    logic                            i_in_valid  = 1'b0;
    logic                            o_in_stall;
    mbf_pkg::t_in_item               i_in_data   = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    mbf_pkg::t_out_item              o_out_data;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [mbf_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [RW-1:0]                   i_cfg_data  = '0;

    shade_scoreboard       board = new();
    int                    in_idle_pct;
    int                    out_idle_pct;
    int                    reach;
    int                    ctr_used;
    int                    anchor_x;
    int                    anchor_y;
    int                    ph;

    metaball_field_pixel_shader #(
        .MAX_CENTERS (MAX_CTR),
        .GRID_SIDE   (GRID)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // random receiver stall
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_result(o_out_data);
    end

    function automatic mbf_pkg::t_in_item make_load(int slot, int x, int y);
        mbf_pkg::t_in_item it;
        it.operation   = mbf_pkg::OP_LOAD;
        it.center_slot = mbf_pkg::SLOT_W'(slot);
        it.center_x    = CW'(x);
        it.center_y    = CW'(y);
        it.pixel_x     = CW'($urandom);
        it.pixel_y     = CW'($urandom);
        it.jitter_x    = mbf_pkg::JIT_W'($urandom);
        it.jitter_y    = mbf_pkg::JIT_W'($urandom);
        return it;
    endfunction

    function automatic mbf_pkg::t_in_item make_shade(int x, int y, int jx, int jy);
        mbf_pkg::t_in_item it;
        it.operation   = mbf_pkg::OP_SHADE;
        it.center_slot = mbf_pkg::SLOT_W'($urandom);
        it.center_x    = CW'($urandom);
        it.center_y    = CW'($urandom);
        it.pixel_x     = CW'(x);
        it.pixel_y     = CW'(y);
        it.jitter_x    = mbf_pkg::JIT_W'(jx);
        it.jitter_y    = mbf_pkg::JIT_W'(jy);
        return it;
    endfunction

    // one input transaction, with random idle cycles ahead of it
    task automatic send_item(input mbf_pkg::t_in_item it);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        board.note_input(it);
    endtask

    // one configuration transaction, with i_cfg_valid dropped afterwards
    task automatic write_reg(input mbf_pkg::t_cfg_idx idx, input logic [RW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait for every pending pixel, then for loads still in flight
    task automatic settle();
        i_in_valid <= 1'b0;
        while (board.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // corners, saturated count, zero reciprocal, empty field, tiny radius
    task automatic run_directed();
        int i;
        send_item(make_load(0, 0, 0));
        send_item(make_load(1, 1023, 0));
        send_item(make_load(2, 0, 1023));
        send_item(make_load(3, 1023, 1023));
        for (i = 4; i < MAX_CTR; i++)
            send_item(make_load(i, 500 + 3 * i, 500 + 2 * i));
        send_item(make_shade(0, 0, 0, 0));
        send_item(make_shade(1023, 1023, 127, 127));
        send_item(make_shade(585, 540, 50, 50));
        settle();
        write_reg(mbf_pkg::CFG_ACTIVE, RW'(31));
        write_reg(mbf_pkg::CFG_RECIP, RW'(0));
        write_reg(mbf_pkg::CFG_THR, RW'({mbf_pkg::THR_W{1'b1}}));
        write_reg(mbf_pkg::CFG_RED, RW'(255));
        write_reg(mbf_pkg::CFG_GREEN, RW'(255));
        write_reg(mbf_pkg::CFG_BLUE, RW'(255));
        send_item(make_shade(300, 700, 99, 0));
        settle();
        write_reg(mbf_pkg::CFG_ACTIVE, RW'(0));
        write_reg(mbf_pkg::CFG_THR, RW'(0));
        send_item(make_shade(500, 500, 0, 99));
        settle();
        write_reg(mbf_pkg::CFG_ACTIVE, RW'(16));
        write_reg(mbf_pkg::CFG_RECIP, RW'(1) << (RW - 1));
        write_reg(mbf_pkg::CFG_RED, RW'(1));
        write_reg(mbf_pkg::CFG_GREEN, RW'(128));
        write_reg(mbf_pkg::CFG_BLUE, RW'(77));
        send_item(make_shade(512, 508, 0, 0));
        send_item(make_shade(503, 502, 64, 127));
        settle();
    endtask

    // new register set and a fresh cluster of centers for one phase
    task automatic randomize_setup(input int phase);
        logic [RW-1:0]               rv;
        logic [mbf_pkg::THR_W-1:0]   thr;
        int                          r, act, i;
        if (phase == 3 || $urandom_range(3) == 0) begin
            rv = RW'({$urandom, $urandom}) >> $urandom_range(8);
        end else begin
            r  = $urandom_range(1, 12);
            rv = RW'((64'd1 << mbf_pkg::S_LIMIT_BIT) / (64'(r * r) * 64'd160000));
        end
        // reach in pixels where a center stops contributing
        reach = 1;
        while (reach < 40 &&
               128'(reach * reach) * 128'd160000 * 128'(rv)
               < (128'd1 << mbf_pkg::S_LIMIT_BIT))
            reach++;
        case ($urandom_range(9))
            0:       act = 0;
            1:       act = $urandom_range(17, 31);
            default: act = $urandom_range(1, 16);
        endcase
        case ($urandom_range(7))
            0:       thr = '0;
            1:       thr = mbf_pkg::THR_W'($urandom);
            default: thr = mbf_pkg::THR_W'($urandom_range(1, 25)) << (mbf_pkg::Q_FRAC - 4);
        endcase
        ctr_used = (act > MAX_CTR) ? MAX_CTR : act;
        write_reg(mbf_pkg::CFG_ACTIVE, RW'(act));
        write_reg(mbf_pkg::CFG_RECIP, rv);
        write_reg(mbf_pkg::CFG_THR, RW'(thr));
        write_reg(mbf_pkg::CFG_RED, RW'($urandom_range(255)));
        write_reg(mbf_pkg::CFG_GREEN, RW'($urandom_range(255)));
        write_reg(mbf_pkg::CFG_BLUE, RW'($urandom_range(255)));
        anchor_x = $urandom_range(1023);
        anchor_y = $urandom_range(1023);
        for (i = 0; i < MAX_CTR; i++)
            send_item(make_load(i, anchor_x + $urandom_range(3 * reach),
                                anchor_y + $urandom_range(3 * reach)));
    endtask

    // mostly shades around active centers, some loads and stray pixels
    task automatic run_random_phase();
        int k, c, span, ox, oy;
        for (k = 0; k < PHASE_ITEMS; k++) begin
            c    = (ctr_used > 0) ? $urandom_range(ctr_used - 1) : $urandom_range(MAX_CTR - 1);
            span = reach + 1;
            ox   = $urandom_range(2 * span) - span;
            oy   = $urandom_range(2 * span) - span;
            case ($urandom_range(19))
                0: send_item(make_load($urandom_range(MAX_CTR - 1),
                                       anchor_x + $urandom_range(3 * reach),
                                       anchor_y + $urandom_range(3 * reach)));
                1, 2: send_item(make_shade($urandom_range(1023), $urandom_range(1023),
                                           $urandom_range(127), $urandom_range(127)));
                default: send_item(make_shade(int'(board.ctr_x[c]) + ox,
                                              int'(board.ctr_y[c]) + oy,
                                              $urandom_range(127), $urandom_range(127)));
            endcase
        end
    endtask

    // main sequence
    initial begin
        in_idle_pct  = 37;
        out_idle_pct = 77;
        reach        = 1;
        ctr_used     = MAX_CTR;
        anchor_x     = 0;
        anchor_y     = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 2) begin
                in_idle_pct  = 77;
                out_idle_pct = 37;
            end
            if (ph == 4) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            randomize_setup(ph);
            run_random_phase();
            settle();
        end
        if (board.mismatches == 0 && board.expected_q.size() == 0)
            $display("metaball_field_pixel_shader verification clean");
        else
            $display("metaball_field_pixel_shader verification failed");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("metaball_field_pixel_shader verification failed");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/mbf_pkg.sv
hw/rtl/mbf_cell.sv
hw/rtl/mbf_chain.sv
hw/rtl/metaball_field_pixel_shader.sv
tb/metaball_field_pixel_shader_tb.sv
